### hw/rtl/prws_pkg.sv
// Shared types, codes and constants of the price return window statistics block.
package prws_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int DATA_W = 32;
    localparam int WIN_W = 9;
    localparam int CFG_IDX_W = 2;

    // Divider operand widths and accumulator widths.
    localparam int DIVD_W = 64;
    localparam int DIVS_W = 32;
    localparam int SUM_W = 41;
    localparam int VSUM_W = 50;
    localparam int ACC_W = 64;

    localparam logic [WIN_W-1:0]  WINDOW_RST = 9'd16;
    localparam logic [DATA_W-1:0] FACTOR_RST = 32'h0001_0000;
    localparam logic [DATA_W-1:0] OFFSET_RST = 32'h0000_0000;
    localparam logic [DATA_W-1:0] LOSS_RST   = 32'h0001_0000;

    localparam logic signed [ACC_W-1:0] ACC_LIMIT = 64'sh4000_0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW = 2'd0,
        CFG_FACTOR = 2'd1,
        CFG_OFFSET = 2'd2,
        CFG_LOSS   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_RET  = 2'd0,
        DIV_MEAN = 2'd1,
        DIV_VAR  = 2'd2,
        DIV_UTL  = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic     load_price;
        logic     write_ret;
        logic     pass_start;
        logic     pass_second;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_capture;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic zero;
        logic div_done;
        logic pass_done;
    } stat_t;

endpackage

### hw/rtl/prws_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module prws_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [prws_pkg::DIVD_W-1:0] dividend,
    input  logic [prws_pkg::DIVS_W-1:0] divisor,
    output logic                        done,
    output logic [prws_pkg::DIVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(prws_pkg::DIVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(prws_pkg::DIVD_W - 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [prws_pkg::DIVS_W-1:0] rem_reg;
    logic [prws_pkg::DIVS_W-1:0] den_reg;
    logic [prws_pkg::DIVD_W-1:0] dq_reg;

    logic [prws_pkg::DIVS_W:0]   shifted;
    logic                        ge;
    logic [prws_pkg::DIVS_W:0]   rem_next;

    assign shifted  = {rem_reg, dq_reg[prws_pkg::DIVD_W-1]};
    assign ge       = shifted >= {1'b0, den_reg};
    assign rem_next = ge ? (shifted - {1'b0, den_reg}) : shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= divisor;
            dq_reg  <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next[prws_pkg::DIVS_W-1:0];
            dq_reg  <= {dq_reg[prws_pkg::DIVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

### hw/rtl/prws_dp.sv
// Datapath: configuration, return ring, window passes, divider and result registers.
module prws_dp #(
    parameter int RING_DEPTH = prws_pkg::RING_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [prws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [prws_pkg::DATA_W-1:0]    cfg_data,
    input  logic [31:0]                    price,
    input  prws_pkg::cmd_t                 cmd,
    output prws_pkg::stat_t                stat,
    output logic signed [31:0]             last_return,
    output logic signed [31:0]             mean_return,
    output logic [31:0]                    return_variance,
    output logic signed [31:0]             utility,
    output logic                           zero_price
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int WIN_W  = prws_pkg::WIN_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(RING_DEPTH);

    // Configuration registers.
    logic [WIN_W-1:0]          window_reg;
    logic signed [31:0]        factor_reg;
    logic signed [31:0]        offset_reg;
    logic [31:0]               loss_reg;

    // Per-item state.
    logic [31:0]               price_reg;
    logic [31:0]               prior_reg;
    logic [31:0]               mag_reg;
    logic                      neg_reg;
    logic                      zero_reg;
    logic signed [31:0]        ret_reg;
    logic [SLOT_W-1:0]         newest_reg;
    logic [FILL_W-1:0]         fill_reg;

    // Ring memory.
    logic [31:0]               ring_mem [RING_DEPTH];
    logic [31:0]               rd_data_reg;
    logic                      rd_ok_reg;

    // Pass sequencing.
    logic                      issuing_reg;
    logic                      second_reg;
    logic [WIN_W-1:0]          cnt_reg;
    logic [SLOT_W-1:0]         rd_slot_reg;
    logic                      v1_reg, v2_reg, v3_reg, v4_reg;

    // Pipeline and accumulators.
    logic signed [prws_pkg::SUM_W-1:0]  sum_reg;
    logic [65:0]                        sq_reg;
    logic signed [63:0]                 fp_reg;
    logic [prws_pkg::VSUM_W-1:0]        vsum_reg;
    logic signed [40:0]                 t_reg;
    logic signed [40:0]                 t4_reg;
    logic signed [57:0]                 ph_reg;
    logic signed [57:0]                 pl_reg;
    logic signed [prws_pkg::ACC_W-1:0]  utl_reg;

    logic signed [31:0]        mean_reg;
    logic [31:0]               var_reg;
    logic signed [31:0]        utlm_reg;

    // Output registers.
    logic signed [31:0]        out_ret_reg;
    logic signed [31:0]        out_mean_reg;
    logic [31:0]               out_var_reg;
    logic signed [31:0]        out_utl_reg;
    logic                      out_zero_reg;

    // Divider connection.
    logic [prws_pkg::DIVD_W-1:0] div_dividend;
    logic [prws_pkg::DIVS_W-1:0] div_divisor;
    logic                        div_done;
    logic [prws_pkg::DIVD_W-1:0] div_q;

    logic [WIN_W-1:0]          win_act;
    logic [SLOT_W-1:0]         newest_inc;
    logic [SLOT_W-1:0]         rd_slot_dec;
    logic signed [32:0]        diff_in;
    logic signed [31:0]        r1;
    logic signed [32:0]        d1;
    logic [32:0]               m1;
    logic signed [40:0]        t2;
    logic signed [63:0]        term;
    logic signed [64:0]        acc_sum;
    logic signed [prws_pkg::ACC_W-1:0] acc_next;
    logic [prws_pkg::SUM_W-1:0] sum_mag;
    logic [prws_pkg::ACC_W-1:0] utl_mag;

    always_comb
    begin
        if (window_reg == '0)
            win_act = WIN_W'(1);
        else if (32'(window_reg) > 32'(RING_DEPTH))
            win_act = WIN_W'(RING_DEPTH);
        else
            win_act = window_reg;
    end

    assign newest_inc  = (newest_reg == LAST_SLOT) ? '0 : newest_reg + 1'b1;
    assign rd_slot_dec = (rd_slot_reg == '0) ? LAST_SLOT : rd_slot_reg - 1'b1;
    assign diff_in     = $signed({1'b0, price}) - $signed({1'b0, prior_reg});

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= prws_pkg::WINDOW_RST;
            factor_reg <= prws_pkg::FACTOR_RST;
            offset_reg <= prws_pkg::OFFSET_RST;
            loss_reg   <= prws_pkg::LOSS_RST;
        end
        else if (cfg_we)
        begin
            unique case (prws_pkg::cfg_idx_t'(cfg_index))
                prws_pkg::CFG_WINDOW: window_reg <= cfg_data[WIN_W-1:0];
                prws_pkg::CFG_FACTOR: factor_reg <= cfg_data;
                prws_pkg::CFG_OFFSET: offset_reg <= cfg_data;
                prws_pkg::CFG_LOSS:   loss_reg   <= cfg_data;
                default:              loss_reg   <= loss_reg;
            endcase
        end
    end

    // Ring bookkeeping and pass control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg   <= '0;
            newest_reg  <= '0;
            fill_reg    <= '0;
            issuing_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.write_ret)
            begin
                prior_reg  <= price_reg;
                newest_reg <= newest_inc;
                if (fill_reg != FULL_FILL)
                    fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.pass_start)
                issuing_reg <= 1'b1;
            else if (issuing_reg && ({1'b0, cnt_reg} + 1'b1 == {1'b0, win_act}))
                issuing_reg <= 1'b0;
            v1_reg <= issuing_reg;
            v2_reg <= v1_reg && second_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_ret)
            ring_mem[newest_inc] <= ret_reg;
        if (issuing_reg)
        begin
            rd_data_reg <= ring_mem[rd_slot_reg];
            rd_ok_reg   <= 32'(cnt_reg) < 32'(fill_reg);
        end
    end

    // Stage one: the return read from the ring, or zero for a slot never written.
    assign r1 = rd_ok_reg ? $signed(rd_data_reg) : 32'sd0;
    assign d1 = $signed({r1[31], r1}) - $signed({mean_reg[31], mean_reg});
    assign m1 = d1[32] ? 33'(-d1) : 33'(d1);

    // Stage two: scaled return in Q16.16 plus offset.
    assign t2 = 41'(fp_reg >>> 24) + 41'(offset_reg);

    // Stage four: loss-weighted term and saturating accumulation.
    always_comb
    begin
        if (t4_reg < 0)
            term = 64'(ph_reg) + 64'(pl_reg >>> 16);
        else
            term = 64'(t4_reg);
        acc_sum = 65'(utl_reg) + 65'(term);
        if (acc_sum > 65'(prws_pkg::ACC_LIMIT))
            acc_next = prws_pkg::ACC_LIMIT;
        else if (acc_sum < -65'(prws_pkg::ACC_LIMIT))
            acc_next = -prws_pkg::ACC_LIMIT;
        else
            acc_next = acc_sum[prws_pkg::ACC_W-1:0];
    end

    assign sum_mag = sum_reg < 0 ? prws_pkg::SUM_W'(-sum_reg) : prws_pkg::SUM_W'(sum_reg);
    assign utl_mag = utl_reg < 0 ? prws_pkg::ACC_W'(-utl_reg) : prws_pkg::ACC_W'(utl_reg);

    always_comb
    begin
        div_divisor = 32'(win_act);
        unique case (cmd.div_sel)
            prws_pkg::DIV_RET:
            begin
                div_dividend = {8'd0, mag_reg, 24'd0};
                div_divisor  = price_reg;
            end
            prws_pkg::DIV_MEAN: div_dividend = 64'(sum_mag);
            prws_pkg::DIV_VAR:  div_dividend = 64'(vsum_reg);
            prws_pkg::DIV_UTL:  div_dividend = utl_mag;
            default:            div_dividend = '0;
        endcase
    end

    prws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_price)
        begin
            price_reg <= price;
            zero_reg  <= price == '0;
            neg_reg   <= diff_in[32];
            mag_reg   <= diff_in[32] ? 32'(-diff_in) : 32'(diff_in);
            ret_reg   <= '0;
        end

        if (cmd.pass_start)
        begin
            second_reg  <= cmd.pass_second;
            cnt_reg     <= '0;
            rd_slot_reg <= newest_reg;
            sum_reg     <= '0;
            vsum_reg    <= '0;
            utl_reg     <= '0;
        end
        else
        begin
            if (issuing_reg)
            begin
                cnt_reg     <= cnt_reg + 1'b1;
                rd_slot_reg <= rd_slot_dec;
            end
            if (v1_reg && !second_reg)
                sum_reg <= sum_reg + prws_pkg::SUM_W'(r1);
            if (v2_reg)
                vsum_reg <= vsum_reg + prws_pkg::VSUM_W'(sq_reg >> 24);
            if (v4_reg)
                utl_reg <= acc_next;
        end

        if (v1_reg)
        begin
            sq_reg <= 66'(m1) * 66'(m1);
            fp_reg <= 64'(r1) * 64'(factor_reg);
        end
        if (v2_reg)
            t_reg <= t2;
        if (v3_reg)
        begin
            t4_reg <= t_reg;
            ph_reg <= 58'(t_reg) * 58'($signed({1'b0, loss_reg[31:16]}));
            pl_reg <= 58'(t_reg) * 58'($signed({1'b0, loss_reg[15:0]}));
        end

        if (cmd.div_capture)
        begin
            unique case (cmd.div_sel)
                prws_pkg::DIV_RET:
                begin
                    if (neg_reg)
                        ret_reg <= (div_q > 64'h8000_0000) ? 32'sh8000_0000
                                                          : 32'(-div_q);
                    else
                        ret_reg <= (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                          : 32'(div_q);
                end
                prws_pkg::DIV_MEAN:
                    mean_reg <= (sum_reg < 0) ? 32'(-div_q) : 32'(div_q);
                prws_pkg::DIV_VAR:
                    var_reg <= (div_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(div_q);
                prws_pkg::DIV_UTL:
                begin
                    if (utl_reg < 0)
                        utlm_reg <= (div_q > 64'h8000_0000) ? 32'sh8000_0000
                                                           : 32'(-div_q);
                    else
                        utlm_reg <= (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                           : 32'(div_q);
                end
                default: utlm_reg <= utlm_reg;
            endcase
        end

        if (cmd.load_out)
        begin
            out_ret_reg  <= ret_reg;
            out_mean_reg <= mean_reg;
            out_var_reg  <= var_reg;
            out_utl_reg  <= utlm_reg;
            out_zero_reg <= zero_reg;
        end
    end

    assign stat.zero      = zero_reg;
    assign stat.div_done  = div_done;
    assign stat.pass_done = !issuing_reg && !v1_reg && !v2_reg && !v3_reg && !v4_reg;

    assign last_return     = out_ret_reg;
    assign mean_return     = out_mean_reg;
    assign return_variance = out_var_reg;
    assign utility         = out_utl_reg;
    assign zero_price      = out_zero_reg;

endmodule

### hw/rtl/prws_ctrl.sv
// Controller: sequences return division, the two window passes and the result divisions.
module prws_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  prws_pkg::stat_t stat,
    output prws_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_RET_DIV, S_RET_WAIT, S_WRITE, S_SUM_GO, S_SUM_RUN,
        S_MEAN_DIV, S_MEAN_WAIT, S_SQ_GO, S_SQ_RUN, S_VAR_DIV, S_VAR_WAIT,
        S_UTL_DIV, S_UTL_WAIT, S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_RET_DIV;
            S_RET_DIV:   state_next = stat.zero ? S_WRITE : S_RET_WAIT;
            S_RET_WAIT:  if (stat.div_done) state_next = S_WRITE;
            S_WRITE:     state_next = S_SUM_GO;
            S_SUM_GO:    state_next = S_SUM_RUN;
            S_SUM_RUN:   if (stat.pass_done) state_next = S_MEAN_DIV;
            S_MEAN_DIV:  state_next = S_MEAN_WAIT;
            S_MEAN_WAIT: if (stat.div_done) state_next = S_SQ_GO;
            S_SQ_GO:     state_next = S_SQ_RUN;
            S_SQ_RUN:    if (stat.pass_done) state_next = S_VAR_DIV;
            S_VAR_DIV:   state_next = S_VAR_WAIT;
            S_VAR_WAIT:  if (stat.div_done) state_next = S_UTL_DIV;
            S_UTL_DIV:   state_next = S_UTL_WAIT;
            S_UTL_WAIT:  if (stat.div_done) state_next = S_OUT;
            S_OUT:       if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.load_price  = (state_reg == S_IDLE) && in_valid;
        cmd.write_ret   = state_reg == S_WRITE;
        cmd.pass_start  = (state_reg == S_SUM_GO) || (state_reg == S_SQ_GO);
        cmd.pass_second = state_reg == S_SQ_GO;
        cmd.load_out    = (state_reg == S_OUT) && out_free;
        unique case (state_reg)
            S_RET_DIV:
            begin
                cmd.div_sel   = prws_pkg::DIV_RET;
                cmd.div_start = !stat.zero;
            end
            S_RET_WAIT:
            begin
                cmd.div_sel     = prws_pkg::DIV_RET;
                cmd.div_capture = stat.div_done;
            end
            S_MEAN_DIV:
            begin
                cmd.div_sel   = prws_pkg::DIV_MEAN;
                cmd.div_start = 1'b1;
            end
            S_MEAN_WAIT:
            begin
                cmd.div_sel     = prws_pkg::DIV_MEAN;
                cmd.div_capture = stat.div_done;
            end
            S_VAR_DIV:
            begin
                cmd.div_sel   = prws_pkg::DIV_VAR;
                cmd.div_start = 1'b1;
            end
            S_VAR_WAIT:
            begin
                cmd.div_sel     = prws_pkg::DIV_VAR;
                cmd.div_capture = stat.div_done;
            end
            S_UTL_DIV:
            begin
                cmd.div_sel   = prws_pkg::DIV_UTL;
                cmd.div_start = 1'b1;
            end
            S_UTL_WAIT:
            begin
                cmd.div_sel     = prws_pkg::DIV_UTL;
                cmd.div_capture = stat.div_done;
            end
            default: cmd.div_sel = prws_pkg::DIV_RET;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted transfer did not start processing");

    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while held");

    a_capture_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_capture |-> stat.div_done)
        else $error("quotient captured before divider finished");

    a_pass_start_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pass_start |-> stat.pass_done)
        else $error("window pass started while another is in flight");
`endif

endmodule

### hw/rtl/price_return_window_statistics.sv
// Top level of the price return window statistics block.
//
// Each input transfer carries one price (unsigned Q16.16) on the in channel.
// The block forms the relative return against the previous price in signed
// Q8.24, stores it in a ring of returns, and then reports one result transfer
// on the out channel: the last return, the mean of the newest window returns,
// their variance (mean squared deviation) and a loss-averse utility.
// A zero price forces a zero return and raises zero_price.
// An item runs a 64-step serial divider four times (return, mean, variance,
// utility; a zero price skips the return division) and reads the ring memory
// in two passes of window entries, one entry per cycle plus pipeline drain.
// One item is processed at a time; in_stall is high while an item is in work.
// Results wait in an output register, so the next price is accepted while a
// stalled result is held; the block finishes the next item and then waits in
// its last step until the held result is taken.
// Reset clears the previous price, the ring fill count and both channels, and
// loads the configuration defaults. Ring slots never written read as zero.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
module price_return_window_statistics #(
    parameter int RING_DEPTH = prws_pkg::RING_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [31:0]                    price,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [31:0]             last_return,
    output logic signed [31:0]             mean_return,
    output logic [31:0]                    return_variance,
    output logic signed [31:0]             utility,
    output logic                           zero_price,
    input  logic                           cfg_we,
    input  logic [prws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [prws_pkg::DATA_W-1:0]    cfg_data
);

    prws_pkg::cmd_t  cmd;
    prws_pkg::stat_t stat;

    // The controller owns the handshakes and the step sequence.
    prws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the ring, the arithmetic and the result registers.
    prws_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .price           (price),
        .cmd             (cmd),
        .stat            (stat),
        .last_return     (last_return),
        .mean_return     (mean_return),
        .return_variance (return_variance),
        .utility         (utility),
        .zero_price      (zero_price)
    );

endmodule

### test/price_return_window_statistics_test.sv
// Self-checking testbench for the price return window statistics block.
module price_return_window_statistics_test;

    // Time from reset to a forced end of the run. This allows for every item at
    // the largest window with both sides idling a third of the time.
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int DEPTH = 256;
    localparam longint ACC_BOUND = 64'sd1 <<< 62;

    // One result transfer, in the block's field widths.
    typedef struct {
        logic signed [31:0] last_return;
        logic signed [31:0] mean_return;
        logic [31:0]        return_variance;
        logic signed [31:0] utility;
        logic               zero_price;
    } window_stats_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [31:0]        price = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] last_return;
    logic signed [31:0] mean_return;
    logic [31:0]        return_variance;
    logic signed [31:0] utility;
    logic               zero_price;
    logic               cfg_we = 1'b0;
    logic [prws_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [prws_pkg::DATA_W-1:0]    cfg_data = '0;

    // Prices waiting to be driven, and statistics waiting to come out.
    logic [31:0]   price_queue[$];
    window_stats_t stats_queue[$];

    // Own copy of the block's state and configuration.
    logic [31:0] prev_price;
    logic [31:0] return_hist[DEPTH];
    logic [7:0]  head_slot;
    logic [8:0]  win_reg;
    logic [31:0] factor_reg;
    logic [31:0] offset_reg;
    logic [31:0] loss_reg;

    int  error_count = 0;
    int  cycle_count = 0;
    // When calm is set, neither side idles; this gives long stretches at full rate.
    bit  calm = 1'b0;
    logic [31:0] walk_price = 32'h0001_0000;

    price_return_window_statistics DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .price           (price),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .last_return     (last_return),
        .mean_return     (mean_return),
        .return_variance (return_variance),
        .utility         (utility),
        .zero_price      (zero_price),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Stored return i steps back from the newest, sign extended.
    function automatic longint past_return(int i);
        logic [7:0] s;
        s = head_slot - 8'(i);
        return longint'(signed'(return_hist[s]));
    endfunction

    // Advances the state by one price and gives the statistics it must produce.
    function automatic window_stats_t window_stats_for(logic [31:0] p);
        window_stats_t r;
        longint ret, diff, q, sum, mean, d, t, utl, w, fac, ofs, la_hi, la_lo;
        longint unsigned mag, m, vsum, var_q;
        ret = 0;
        if (p != 0)
        begin
            diff = longint'(p) - longint'(prev_price);
            mag = longint'(diff < 0 ? -diff : diff);
            mag = mag << 24;
            q = longint'(mag / longint'({32'd0, p}));
            ret = sat_s32(diff < 0 ? -q : q);
        end
        w = (win_reg == 0) ? 1 : ((win_reg > DEPTH) ? DEPTH : longint'(win_reg));
        head_slot = head_slot + 8'd1;
        return_hist[head_slot] = ret[31:0];
        prev_price = p;

        sum = 0;
        for (int i = 0; i < w; i++)
        begin
            sum += past_return(i);
        end
        mean = sum / w;

        vsum = 0;
        for (int i = 0; i < w; i++)
        begin
            d = past_return(i) - mean;
            m = longint'(d < 0 ? -d : d);
            vsum += (m * m) >> 24;
        end
        var_q = vsum / longint'(w);
        if (var_q > 64'hFFFF_FFFF)
        begin
            var_q = 64'hFFFF_FFFF;
        end

        // Negative utility terms are weighted by loss aversion, split into its
        // integer and fractional halves so that the product stays in range.
        fac = longint'(signed'(factor_reg));
        ofs = longint'(signed'(offset_reg));
        la_hi = longint'(loss_reg[31:16]);
        la_lo = longint'(loss_reg[15:0]);
        utl = 0;
        for (int i = 0; i < w; i++)
        begin
            t = ((past_return(i) * fac) >>> 24) + ofs;
            if (t < 0)
            begin
                t = t * la_hi + ((t * la_lo) >>> 16);
            end
            utl += t;
            if (utl > ACC_BOUND)
            begin
                utl = ACC_BOUND;
            end
            if (utl < -ACC_BOUND)
            begin
                utl = -ACC_BOUND;
            end
        end
        utl = sat_s32(utl / w);

        r.last_return = ret[31:0];
        r.mean_return = mean[31:0];
        r.return_variance = var_q[31:0];
        r.utility = utl[31:0];
        r.zero_price = (p == 0);
        return r;
    endfunction

    // Driver: presents queued prices and predicts each accepted transfer.
    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            next_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                stats_queue.push_back(window_stats_for(price));
                next_valid = 1'b0;
            end
            if (!next_valid && price_queue.size() > 0
                && (calm || $urandom_range(99) >= 33))
            begin
                price <= price_queue.pop_front();
                next_valid = 1'b1;
            end
            in_valid <= next_valid;
        end
    end

    // Monitor: compares each result transfer with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        window_stats_t exp_s;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (stats_queue.size() == 0)
                begin
                    $error("result transfer with no prediction waiting");
                    error_count++;
                end
                else
                begin
                    exp_s = stats_queue.pop_front();
                    if (last_return !== exp_s.last_return)
                    begin
                        $error("last_return expected %0d got %0d",
                               exp_s.last_return, last_return);
                        error_count++;
                    end
                    if (mean_return !== exp_s.mean_return)
                    begin
                        $error("mean_return expected %0d got %0d",
                               exp_s.mean_return, mean_return);
                        error_count++;
                    end
                    if (return_variance !== exp_s.return_variance)
                    begin
                        $error("return_variance expected %0d got %0d",
                               exp_s.return_variance, return_variance);
                        error_count++;
                    end
                    if (utility !== exp_s.utility)
                    begin
                        $error("utility expected %0d got %0d", exp_s.utility, utility);
                        error_count++;
                    end
                    if (zero_price !== exp_s.zero_price)
                    begin
                        $error("zero_price expected %0b got %0b",
                               exp_s.zero_price, zero_price);
                        error_count++;
                    end
                end
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Writes one register of the block and of the predictor's copy.
    task automatic write_reg(prws_pkg::cfg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            prws_pkg::CFG_WINDOW: win_reg = value[8:0];
            prws_pkg::CFG_FACTOR: factor_reg = value;
            prws_pkg::CFG_OFFSET: offset_reg = value;
            prws_pkg::CFG_LOSS:   loss_reg = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] win, logic [31:0] fac, logic [31:0] ofs,
                              logic [31:0] la);
        write_reg(prws_pkg::CFG_WINDOW, win);
        write_reg(prws_pkg::CFG_FACTOR, fac);
        write_reg(prws_pkg::CFG_OFFSET, ofs);
        write_reg(prws_pkg::CFG_LOSS, la);
    endtask

    // Mostly a random walk so that windows hold realistic returns; the rest are
    // zero prices, extremes and fully random values that reach every bit.
    function automatic logic [31:0] next_price();
        int pick;
        logic [31:0] step;
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            return 32'd0;
        end
        if (pick < 10)
        begin
            return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'd1;
        end
        if (pick < 25)
        begin
            walk_price = $urandom();
            return walk_price;
        end
        step = $urandom_range(walk_price[31:4] + 1);
        if ($urandom_range(1) != 0 && walk_price > step)
        begin
            walk_price = walk_price - step;
        end
        else if (walk_price < 32'hF000_0000)
        begin
            walk_price = walk_price + step;
        end
        if (walk_price == 0)
        begin
            walk_price = 32'h0001_0000;
        end
        return walk_price;
    endfunction

    // Waits until every queued price has been taken and every result checked.
    // The check runs at the falling edge, after the driver's updates have settled.
    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (price_queue.size() != 0 || in_valid || stats_queue.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            price_queue.push_back(next_price());
        end
        drain();
    endtask

    initial
    begin
        prev_price = '0;
        head_slot = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            return_hist[i] = '0;
        end
        win_reg = prws_pkg::WINDOW_RST;
        factor_reg = prws_pkg::FACTOR_RST;
        offset_reg = prws_pkg::OFFSET_RST;
        loss_reg = prws_pkg::LOSS_RST;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed prices under the reset configuration: a zero first price, a
        // price after a zero, the largest rise and fall, an unchanged price and
        // the extreme values of the field.
        calm = 1'b1;
        price_queue = '{32'd0, 32'h0001_0000, 32'h0001_0000, 32'd1, 32'hFFFF_FFFF,
                        32'd1, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h0001_8000, 32'h0001_0000, 32'hAAAA_5555, 32'h5555_AAAA,
                        32'd2, 32'd3};
        drain();

        // Window zero behaves as one, window beyond the ring as the ring.
        calm = 1'b0;
        set_config(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        random_phase(40);
        set_config(32'd256, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        random_phase(30);
        set_config(32'd511, 32'hFFFF_0000, 32'h0000_8000, 32'h0002_8000);
        random_phase(25);
        set_config(32'd1, 32'h0001_0000, 32'd0, 32'h0001_0000);
        random_phase(60);

        // A long stretch with no idling on either side.
        calm = 1'b1;
        set_config(32'd8, 32'h0003_0000, 32'hFFFF_0000, 32'h0002_0000);
        random_phase(150);

        calm = 1'b0;
        for (int ph = 0; ph < 8; ph++)
        begin
            set_config($urandom_range(2, 40), $urandom(), $urandom(), $urandom());
            random_phase(80);
        end

        repeat (50) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/prws_pkg.sv
hw/rtl/prws_div.sv
hw/rtl/prws_dp.sv
hw/rtl/prws_ctrl.sv
hw/rtl/price_return_window_statistics.sv
test/price_return_window_statistics_test.sv
